### hdl/mfe_pkg.sv
// Shared types, constants and helper functions of the frame buffer engine.
package mfe_pkg;

    localparam int DEF_COLUMNS = 128;
    localparam int WORD_W = 64;
    localparam int ACT_W = 4;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 80;

    typedef enum logic [3:0] {
        ACT_WRITE   = 4'd0,
        ACT_UP      = 4'd1,
        ACT_DOWN    = 4'd2,
        ACT_LEFT    = 4'd3,
        ACT_RIGHT   = 4'd4,
        ACT_ZOOMIN  = 4'd5,
        ACT_ZOOMOUT = 4'd6,
        ACT_REFRESH = 4'd7,
        ACT_COMMIT  = 4'd8
    } action_t;

    typedef struct packed {
        logic [3:0] action;
        logic [7:0] column;
        logic [7:0] row_offset;
        logic [7:0] segment_byte;
        logic [7:0] amount;
        logic [2:0] threshold;
        logic [3:0] first_page;
        logic [3:0] last_page;
        logic       force_all;
    } cmd_t;

    function automatic logic [63:0] zoom_in_word(input logic [63:0] src);
        logic [63:0] w;
        w = '0;
        for (int r = 0; r < 32; r++) begin
            w[2*r]   = src[r];
            w[2*r+1] = src[r];
        end
        return w;
    endfunction

    function automatic logic [63:0] zoom_out_word(input logic [63:0] a,
                                                  input logic [63:0] b,
                                                  input logic [2:0] thr);
        logic [63:0] w;
        logic [2:0]  k;
        w = '0;
        for (int r = 0; r < 32; r++) begin
            k = 3'(a[2*r]) + 3'(a[2*r+1]) + 3'(b[2*r]) + 3'(b[2*r+1]);
            w[r] = (k >= thr);
        end
        return w;
    endfunction

endpackage

### hdl/mfe_word_unit.sv
// Shared per-column word unit: rotate, segment insert, zoom and page compare.
module mfe_word_unit (
    input  mfe_pkg::cmd_t        cmd,
    input  logic [5:0]           rot_amt,
    input  logic [2:0]           thr,
    input  logic [63:0]          word_a,
    input  logic [63:0]          word_b,
    input  logic [63:0]          shown,
    output logic [63:0]          word_out,
    output logic [7:0]           page_mask
);
    import mfe_pkg::*;

    logic [127:0] dbl;
    logic [5:0]   row;
    logic [2:0]   p1;
    logic [2:0]   p2;

    assign dbl = {word_a, word_a};
    assign row = (cmd.row_offset > 8'd55) ? 6'd55 : cmd.row_offset[5:0];
    assign p1  = (cmd.first_page > 4'd7) ? 3'd7 : cmd.first_page[2:0];
    assign p2  = (cmd.last_page > 4'd7) ? 3'd7 : cmd.last_page[2:0];

    always_comb begin
        word_out = word_a;
        unique case (cmd.action)
            ACT_WRITE: word_out = (word_a & ~(64'hff << row))
                                | (64'(cmd.segment_byte) << row);
            ACT_UP: word_out = dbl[rot_amt +: 64];
            ACT_DOWN: word_out = dbl[7'd64 - {1'b0, rot_amt} +: 64];
            ACT_ZOOMIN: word_out = zoom_in_word(word_a);
            ACT_ZOOMOUT: word_out = zoom_out_word(word_a, word_b, thr);
            default: word_out = word_a;
        endcase
    end

    always_comb begin
        for (int p = 0; p < 8; p++) begin
            page_mask[p] = (3'(p) >= p1) && (3'(p) <= p2)
                        && (cmd.force_all || word_a[8*p +: 8] != shown[8*p +: 8]);
        end
    end

endmodule

### hdl/mono_framebuffer_engine_unit.sv
// Top level of the frame buffer engine: sequencer, image memories and output register.
// Write and refresh read one column, then apply; commit copies every column in one pass.
// Scroll and zoom_in make a copy pass, then a read and a write per column.
// Zoom_out reads two source words per column before each write.
// A refresh result waits in an output register while the next command proceeds.
// Reset clears both images in a pass over all columns before s_tready rises.
module mono_framebuffer_engine_unit #(
    parameter int COLUMNS = mfe_pkg::DEF_COLUMNS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // action, column, row_offset, segment_byte, amount, threshold,
    // first_page, last_page, force_all (from the lowest bit up)
    input  logic [mfe_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // column_word, page_mask, column_index (from the lowest bit up)
    output logic [mfe_pkg::M_TDATA_W-1:0] m_tdata
);
    import mfe_pkg::*;

    localparam int CW = $clog2(COLUMNS);
    localparam int HALF = (COLUMNS + 1) / 2;

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_READ, ST_APPLY, ST_COPY, ST_ZA, ST_ZB, ST_DONE
    } state_t;

    state_t state_reg;
    cmd_t cmd_reg;
    logic [CW:0] cnt_reg;
    logic [CW-1:0] col_reg;
    logic [CW-1:0] shift_reg;
    logic [63:0] image_mem [COLUMNS];
    logic [63:0] shown_mem [COLUMNS];
    logic [63:0] scratch_mem [COLUMNS];
    logic [63:0] rd_img_reg;
    logic [63:0] rd_shown_reg;
    logic [63:0] rd_a_reg;
    logic [63:0] rd_b_reg;
    logic [63:0] wout;
    logic [7:0] pmask;
    logic [5:0] rot_amt;
    logic [2:0] thr;
    logic [CW:0] src_sum;
    logic [CW-1:0] src_idx;
    logic [7:0] amt_h;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic m_tvalid_reg;
    logic out_busy;
    logic out_load;
    cmd_t s_cmd;
    logic [7:0] col_c;

    assign s_cmd.action       = s_tdata[3:0];
    assign s_cmd.column       = s_tdata[11:4];
    assign s_cmd.row_offset   = s_tdata[19:12];
    assign s_cmd.segment_byte = s_tdata[27:20];
    assign s_cmd.amount       = s_tdata[35:28];
    assign s_cmd.threshold    = s_tdata[38:36];
    assign s_cmd.first_page   = s_tdata[42:39];
    assign s_cmd.last_page    = s_tdata[46:43];
    assign s_cmd.force_all    = s_tdata[47];

    assign col_c = (s_cmd.column > 8'(COLUMNS - 1)) ? 8'(COLUMNS - 1) : s_cmd.column;
    assign rot_amt = (cmd_reg.amount == 8'd0) ? 6'd1
                   : (cmd_reg.amount > 8'd63) ? 6'd63 : cmd_reg.amount[5:0];
    assign thr = (cmd_reg.threshold == 3'd0) ? 3'd1
               : (cmd_reg.threshold > 3'd4) ? 3'd4 : cmd_reg.threshold;
    assign amt_h = (cmd_reg.amount == 8'd0) ? 8'd1
                 : (cmd_reg.amount > 8'(COLUMNS - 1)) ? 8'(COLUMNS - 1) : cmd_reg.amount;

    // Source column of a horizontal move for the column in col_reg.
    assign src_sum = {1'b0, col_reg} + {1'b0, shift_reg};
    assign src_idx = (src_sum >= (CW+1)'(COLUMNS)) ? CW'(src_sum - (CW+1)'(COLUMNS))
                                                   : src_sum[CW-1:0];

    mfe_word_unit u_word (
        .cmd      (cmd_reg),
        .rot_amt  (rot_amt),
        .thr      (thr),
        .word_a   ((state_reg == ST_ZB) ? rd_a_reg : rd_img_reg),
        .word_b   (rd_b_reg),
        .shown    (rd_shown_reg),
        .word_out (wout),
        .page_mask(pmask)
    );

    assign out_busy = m_tvalid_reg && !m_tready;
    assign out_load = (state_reg == ST_APPLY) && (cmd_reg.action == ACT_REFRESH) && !out_busy;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            cnt_reg <= '0;
            col_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_tdata_reg <= {1'b0, 7'(col_reg), pmask, rd_img_reg};
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR: begin
                    image_mem[cnt_reg[CW-1:0]] <= '0;
                    shown_mem[cnt_reg[CW-1:0]] <= '0;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == (CW+1)'(COLUMNS - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_tvalid && s_tready) begin
                        cmd_reg <= s_cmd;
                        cnt_reg <= '0;
                        if (s_cmd.action == ACT_WRITE || s_cmd.action == ACT_REFRESH) begin
                            col_reg <= col_c[CW-1:0];
                            state_reg <= ST_READ;
                        end else if (s_cmd.action <= ACT_COMMIT) begin
                            col_reg <= '0;
                            state_reg <= ST_COPY;
                        end
                    end
                end
                ST_READ: begin
                    rd_img_reg <= image_mem[col_reg];
                    rd_shown_reg <= shown_mem[col_reg];
                    state_reg <= ST_APPLY;
                end
                ST_APPLY: begin
                    if (cmd_reg.action != ACT_REFRESH) begin
                        image_mem[col_reg] <= wout;
                        state_reg <= ST_IDLE;
                    end else if (!out_busy) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_COPY: begin
                    // Pass 1: copy image to scratch (and also to last_shown on commit).
                    scratch_mem[col_reg] <= image_mem[col_reg];
                    if (cmd_reg.action == ACT_COMMIT) begin
                        shown_mem[col_reg] <= image_mem[col_reg];
                    end
                    if (col_reg == CW'(COLUMNS - 1)) begin
                        col_reg <= '0;
                        shift_reg <= (cmd_reg.action == ACT_RIGHT)
                                   ? CW'(COLUMNS - 32'(amt_h)) : CW'(amt_h);
                        cnt_reg <= '0;
                        state_reg <= (cmd_reg.action == ACT_COMMIT) ? ST_IDLE : ST_ZA;
                    end else begin
                        col_reg <= col_reg + 1'b1;
                    end
                end
                ST_ZA: begin
                    // Fetch the first (or only) source word for the column in col_reg.
                    if (cmd_reg.action == ACT_LEFT || cmd_reg.action == ACT_RIGHT) begin
                        rd_a_reg <= scratch_mem[src_idx];
                    end else if (cmd_reg.action == ACT_ZOOMIN) begin
                        rd_a_reg <= scratch_mem[col_reg >> 1];
                    end else if (cmd_reg.action == ACT_ZOOMOUT) begin
                        rd_a_reg <= (32'(col_reg) < HALF) ? scratch_mem[CW'({col_reg, 1'b0})] : '0;
                    end else begin
                        rd_a_reg <= scratch_mem[col_reg];
                    end
                    state_reg <= (cmd_reg.action == ACT_ZOOMOUT) ? ST_DONE : ST_ZB;
                end
                ST_DONE: begin
                    rd_b_reg <= (32'(col_reg) < HALF && 2 * 32'(col_reg) + 1 < COLUMNS)
                              ? scratch_mem[CW'({col_reg, 1'b1})] : '0;
                    state_reg <= ST_ZB;
                end
                ST_ZB: begin
                    if (cmd_reg.action == ACT_ZOOMOUT) begin
                        image_mem[col_reg] <= (32'(col_reg) < HALF) ? wout : '0;
                    end else if (cmd_reg.action == ACT_LEFT || cmd_reg.action == ACT_RIGHT) begin
                        image_mem[col_reg] <= rd_a_reg;
                    end else begin
                        image_mem[col_reg] <= wout;
                    end
                    col_reg <= col_reg + 1'b1;
                    state_reg <= (col_reg == CW'(COLUMNS - 1)) ? ST_IDLE : ST_ZA;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !out_load |=> !m_tvalid)
        else $error("result repeated after its transaction");
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg) == ST_APPLY)
        else $error("result not from refresh");

endmodule

### sim/tb_mono_framebuffer_engine_unit.sv
// Self-checking testbench of the frame buffer engine with a scoreboard and random stimulus.
`timescale 1ns / 100ps

class frame_scoreboard;
    logic [63:0] image [128];
    logic [63:0] shown [128];
    logic [78:0] pending [$];
    int errors;

    function void clear_state();
        for (int c = 0; c < 128; c++) begin
            image[c] = '0;
            shown[c] = '0;
        end
        pending.delete();
        errors = 0;
    endfunction

    function void note_command(logic [47:0] d);
        logic [3:0]  act;
        int          col, row, amt, thr, p1, p2, src, k;
        logic [7:0]  seg, mask;
        logic        frc;
        logic [63:0] tmp [128];
        logic [63:0] w, a, b;
        act = d[3:0];
        col = d[11:4];
        row = d[19:12];
        seg = d[27:20];
        amt = d[35:28];
        thr = d[38:36];
        p1 = d[42:39];
        p2 = d[46:43];
        frc = d[47];
        if (col > 127) col = 127;
        tmp = image;
        case (act)
            mfe_pkg::ACT_WRITE: begin
                if (row > 55) row = 55;
                image[col] = (image[col] & ~(64'hff << row)) | (64'(seg) << row);
            end
            mfe_pkg::ACT_UP, mfe_pkg::ACT_DOWN: begin
                if (amt < 1) amt = 1;
                if (amt > 63) amt = 63;
                for (int c = 0; c < 128; c++) begin
                    w = tmp[c];
                    image[c] = (act == mfe_pkg::ACT_UP) ? ((w >> amt) | (w << (64 - amt)))
                                                        : ((w << amt) | (w >> (64 - amt)));
                end
            end
            mfe_pkg::ACT_LEFT, mfe_pkg::ACT_RIGHT: begin
                if (amt < 1) amt = 1;
                if (amt > 127) amt = 127;
                for (int c = 0; c < 128; c++) begin
                    src = (act == mfe_pkg::ACT_LEFT) ? (c + amt) % 128 : (c + 128 - amt) % 128;
                    image[c] = tmp[src];
                end
            end
            mfe_pkg::ACT_ZOOMIN: begin
                for (int c = 0; c < 128; c++) begin
                    w = '0;
                    for (int r = 0; r < 32; r++) begin
                        w[2*r] = tmp[c/2][r];
                        w[2*r+1] = tmp[c/2][r];
                    end
                    image[c] = w;
                end
            end
            mfe_pkg::ACT_ZOOMOUT: begin
                if (thr < 1) thr = 1;
                if (thr > 4) thr = 4;
                for (int c = 0; c < 128; c++) image[c] = '0;
                for (int c = 0; c < 64; c++) begin
                    a = tmp[2*c];
                    b = tmp[2*c+1];
                    w = '0;
                    for (int r = 0; r < 32; r++) begin
                        k = a[2*r] + a[2*r+1] + b[2*r] + b[2*r+1];
                        w[r] = (k >= thr);
                    end
                    image[c] = w;
                end
            end
            mfe_pkg::ACT_REFRESH: begin
                if (p1 > 7) p1 = 7;
                if (p2 > 7) p2 = 7;
                mask = '0;
                for (int p = p1; p <= p2; p++)
                    if (frc || image[col][8*p +: 8] != shown[col][8*p +: 8]) mask[p] = 1'b1;
                pending.push_back({7'(col), mask, image[col]});
            end
            mfe_pkg::ACT_COMMIT: shown = image;
            default: ;
        endcase
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("mismatch %s: got %h expected %h", what, got, want);
    endtask

    task check_result(logic [79:0] d);
        logic [78:0] e;
        if (pending.size() == 0) begin
            report("unexpected transaction", d[63:0], 0);
            return;
        end
        e = pending.pop_front();
        if (d[63:0] != e[63:0]) report("column_word", d[63:0], e[63:0]);
        if (d[71:64] != e[71:64]) report("page_mask", 64'(d[71:64]), 64'(e[71:64]));
        if (d[78:72] != e[78:72]) report("column_index", 64'(d[78:72]), 64'(e[78:72]));
    endtask
endclass

module tb_mono_framebuffer_engine_unit;
    import mfe_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;
    frame_scoreboard board;

    mono_framebuffer_engine_unit DUT (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_command(input logic [47:0] d);
        int gap;
        gap = gap_len();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_command(d);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (board.pending.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [47:0] make_cmd(logic [3:0] act);
        logic [47:0] d;
        d = 48'({$urandom, $urandom});
        d[3:0] = act;
        return d;
    endfunction

    function automatic logic [3:0] pick_action();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40) return ACT_WRITE;
        if (roll < 70) return ACT_REFRESH;
        if (roll < 76) return ACT_COMMIT;
        if (roll < 78) return 4'($urandom_range(9, 15));
        return 4'($urandom_range(1, 6));
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            board.check_result(m_tdata);
        end
    end

    initial begin
        int gap;
        @(posedge aclk);
        while (1) begin
            gap = gap_len();
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            gap = $urandom_range(1, 20);
            repeat (gap) @(posedge aclk);
        end
    end

    initial begin
        logic [47:0] d;
        board = new();
        board.clear_state();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        d = '0; d[3:0] = ACT_REFRESH; d[46:43] = 4'd15; send_command(d);
        d = '1; d[3:0] = ACT_WRITE; send_command(d);
        d = '1; d[3:0] = ACT_REFRESH; send_command(d);
        d = '0; d[3:0] = ACT_WRITE; d[27:20] = 8'ha5; d[19:12] = 8'd9; send_command(d);
        d = '0; d[3:0] = ACT_REFRESH; d[42:39] = 4'd5; d[46:43] = 4'd2; send_command(d);
        d = '0; d[3:0] = ACT_REFRESH; d[46:43] = 4'd7; send_command(d);
        d = '0; d[3:0] = ACT_COMMIT; send_command(d);
        d = '0; d[3:0] = ACT_REFRESH; d[46:43] = 4'd7; send_command(d);
        d = '0; d[3:0] = ACT_REFRESH; d[46:43] = 4'd7; d[47] = 1'b1; send_command(d);
        d = '0; d[3:0] = ACT_UP; send_command(d);
        d = '1; d[3:0] = ACT_DOWN; send_command(d);
        d = '0; d[3:0] = ACT_LEFT; send_command(d);
        d = '1; d[3:0] = ACT_RIGHT; send_command(d);
        d = '0; d[3:0] = ACT_ZOOMIN; send_command(d);
        d = '0; d[3:0] = ACT_ZOOMOUT; send_command(d);
        d = '1; d[3:0] = ACT_ZOOMOUT; send_command(d);
        d = '1; d[3:0] = 4'd15; send_command(d);
        d = '1; d[3:0] = ACT_REFRESH; d[11:4] = 8'd0; send_command(d);
        for (int i = 0; i < 400; i++) begin
            if (i == 200) begin
                drain();
            end
            send_command(make_cmd(pick_action()));
        end
        drain();
        repeat (300) @(posedge aclk);
        if (board.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
